>>> hdl/pgi_pkg.sv
// package: shared types, constants and fixed point helpers for the geodesic integrator
`default_nettype none
package pgi_pkg;
    localparam int FRAC_BITS = 24;
    localparam int MAX_STEPS = 6000;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 2'd2;
    localparam logic [63:0] SATV  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NSATV = 64'h8000_0000_0000_0001;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_CROSS, OP_L2, OP_K1, OP_K2, OP_R2, OP_R4, OP_R6,
        OP_MOVE, OP_KP, OP_DIV, OP_DADD, OP_NRM2, OP_SQRT, OP_NORM
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
        logic [1:0] lane;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic in_band;
        logic escaped;
    } t_sts;

    function automatic logic [63:0] magn(input logic [63:0] a);
        magn = a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic [63:0] apply_sign(input logic [63:0] m, input logic neg);
        logic [63:0] v;
        v = m[63] ? SATV : m;
        apply_sign = neg ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64:63] == 2'b01)               sadd = SATV;
        else if (s[64:63] == 2'b10 || s[63:0] == 64'h8000_0000_0000_0000) sadd = NSATV;
        else                                 sadd = s[63:0];
    endfunction
endpackage
`default_nettype wire

>>> hdl/pgi_if.sv
// interfaces: ray request, result and configuration channels
`default_nettype none
interface pgi_ray_if;
    logic valid;
    logic ready;
    logic signed [31:0] pos_x, pos_y, pos_z, dir_x, dir_y, dir_z;
    modport source (output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface pgi_res_if;
    logic valid;
    logic ready;
    logic escaped;
    logic signed [31:0] out_dir_x, out_dir_y, out_dir_z;
    modport source (output valid, escaped, out_dir_x, out_dir_y, out_dir_z, input ready);
    modport sink   (input valid, escaped, out_dir_x, out_dir_y, out_dir_z, output ready);
endinterface

interface pgi_cfg_if;
    logic valid;
    logic ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/pgi_mul.sv
// multiplier: 64x64 signed fixed point product, four 32x32 partial products over cycles
`default_nettype none
module pgi_mul
    import pgi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_p
);
    logic [63:0]  r_ma, r_mb;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic         r_run;
    logic [63:0]  r_pp;
    logic [31:0]  w_x, w_y;
    logic [127:0] w_sh;
    logic [127:0] w_q;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin w_x = r_ma[31:0];  w_y = r_mb[31:0];  end
            2'd1:    begin w_x = r_ma[31:0];  w_y = r_mb[63:32]; end
            2'd2:    begin w_x = r_ma[63:32]; w_y = r_mb[31:0];  end
            default: begin w_x = r_ma[63:32]; w_y = r_mb[63:32]; end
        endcase
    end

    // partial product registered, accumulated in the following cycle
    always_comb begin
        case (r_cnt)
            3'd2:    w_sh = {32'd0, r_pp, 32'd0};
            3'd3:    w_sh = {32'd0, r_pp, 32'd0};
            3'd4:    w_sh = {r_pp, 64'd0};
            default: w_sh = {64'd0, r_pp};
        endcase
    end

    assign w_q = r_acc >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_ma  <= magn(i_a);
                r_mb  <= magn(i_b);
                r_neg <= i_a[63] ^ i_b[63];
                r_acc <= '0;
            end else if (r_run) begin
                r_pp  <= 64'(w_x) * 64'(w_y);
                if (r_cnt != 3'd0) r_acc <= r_acc + w_sh;
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_p = apply_sign((w_q[127:64] != 64'd0) ? SATV : w_q[63:0], r_neg);
endmodule
`default_nettype wire

>>> hdl/pgi_div.sv
// divider: restoring fixed point quotient and integer square root, one bit per cycle
`default_nettype none
module pgi_div
    import pgi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_sqrt,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_q
);
    localparam int NB = 64 + FRAC_BITS;
    logic [NB-1:0] r_num;
    logic [64:0]   r_rem;
    logic [63:0]   r_den, r_q;
    logic [6:0]    r_cnt;
    logic          r_run, r_neg, r_sq, r_ovf;
    logic [65:0]   w_rem2, w_trial, w_diff;
    logic [1:0]    w_pair;

    // sqrt: remainder takes two bits, trial = 4*root+1
    assign w_pair  = r_num[NB-1:NB-2];
    assign w_rem2  = r_sq ? {r_rem[63:0], w_pair} : {r_rem, r_num[NB-1]};
    assign w_trial = r_sq ? {r_q, 2'b01} : {2'b00, r_den};
    assign w_diff  = w_rem2 - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_sq  <= i_sqrt;
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= 1'b0;
                if (i_sqrt) begin
                    r_num <= i_a[63] ? '0 : NB'(i_a) << FRAC_BITS;
                    r_cnt <= 7'(NB / 2);
                    r_neg <= 1'b0;
                    r_run <= 1'b1;
                end else if (i_b == 64'd0) begin
                    o_done <= 1'b1;
                    r_q    <= '0;
                    r_ovf  <= i_a != 64'd0;
                    r_neg  <= i_a[63];
                end else begin
                    r_num <= NB'(magn(i_a)) << FRAC_BITS;
                    r_den <= magn(i_b);
                    r_neg <= i_a[63] ^ i_b[63];
                    r_cnt <= 7'(NB);
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                r_num <= r_sq ? r_num << 2 : r_num << 1;
                if (!w_diff[65]) begin
                    r_rem <= w_diff[64:0];
                    if (r_q[63]) r_ovf <= 1'b1;
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_rem2[64:0];
                    if (r_q[63]) r_ovf <= 1'b1;
                    r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_q = apply_sign(r_ovf ? SATV : r_q, r_neg);
endmodule
`default_nettype wire

>>> hdl/pgi_datapath.sv
// datapath: ray registers, shared multiplier and divider, saturating adder
`default_nettype none
module pgi_datapath
    import pgi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [31:0] i_in [6],
    input  wire logic [24:0] i_step,
    input  wire logic [31:0] i_cap,
    input  wire logic [31:0] i_esc,
    output logic [31:0]      o_dir [3]
);
    logic [63:0] r_p [3];
    logic [63:0] r_d [3];
    logic [63:0] r_c [3];
    logic [63:0] r_t, r_u, r_k, r_r2, r_r6, r_nrm;
    logic [63:0] w_a, w_b, w_da, w_db;
    logic        w_mstart, w_dstart, w_sqrt;
    logic        w_mdone, w_ddone;
    logic [63:0] w_mp, w_dq;
    logic        r_wait, r_esc;
    logic [1:0]  r_ph;
    logic [1:0]  w_l1, w_l2;
    t_op         r_op;
    logic [1:0]  r_lane;

    always_comb begin
        case (r_lane)
            2'd0:    begin w_l1 = 2'd1; w_l2 = 2'd2; end
            2'd1:    begin w_l1 = 2'd2; w_l2 = 2'd0; end
            default: begin w_l1 = 2'd0; w_l2 = 2'd1; end
        endcase
    end

    // operand select for the multiplier and divider, by op and phase
    always_comb begin
        w_a = '0; w_b = '0; w_da = '0; w_db = '0; w_sqrt = 1'b0;
        case (r_op)
            OP_CROSS: if (r_ph == 2'd0) begin w_a = r_p[w_l1]; w_b = r_d[w_l2]; end
                      else begin w_a = r_d[w_l1]; w_b = r_p[w_l2]; end
            OP_L2:    begin w_a = r_c[r_lane]; w_b = r_c[r_lane]; end
            OP_K1:    begin w_a = r_t; w_b = 64'(i_step); end
            OP_K2:    begin w_a = 64'd0 - (64'd3 << (FRAC_BITS - 1)); w_b = r_t; end
            OP_R2:    begin w_a = r_p[r_lane]; w_b = r_p[r_lane]; end
            OP_R4:    begin w_a = r_r2; w_b = r_r2; end
            OP_R6:    begin w_a = r_t; w_b = r_r2; end
            OP_MOVE:  begin w_a = r_d[r_lane]; w_b = 64'(i_step); end
            OP_KP:    begin w_a = r_k; w_b = r_p[r_lane]; end
            OP_NRM2:  begin w_a = r_d[r_lane]; w_b = r_d[r_lane]; end
            default:  ;
        endcase
        case (r_op)
            OP_DIV:  begin w_da = r_u; w_db = r_r6; end
            OP_SQRT: begin w_da = r_t; w_sqrt = 1'b1; end
            OP_NORM: begin w_da = r_d[r_lane]; w_db = r_nrm; end
            default: ;
        endcase
    end

    assign w_mstart = r_wait && r_ph != 2'd3 && !(r_op == OP_DIV || r_op == OP_SQRT
                      || r_op == OP_NORM || r_op == OP_LOAD || r_op == OP_DADD);
    assign w_dstart = r_wait && r_ph != 2'd3 && (r_op == OP_DIV || r_op == OP_SQRT
                      || r_op == OP_NORM);

    pgi_mul u_mul (
        .i_clk, .i_rst_n, .i_start(w_mstart), .i_a(w_a), .i_b(w_b),
        .o_done(w_mdone), .o_p(w_mp)
    );

    pgi_div u_div (
        .i_clk, .i_rst_n, .i_start(w_dstart), .i_sqrt(w_sqrt), .i_a(w_da), .i_b(w_db),
        .o_done(w_ddone), .o_q(w_dq)
    );

    // r_ph: 0 launch, 3 waiting on unit; cross uses a second launch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= 1'b0;
            r_ph   <= 2'd0;
            r_op   <= OP_NONE;
            r_lane <= 2'd0;
            r_esc  <= 1'b0;
        end else if (i_cmd.start) begin
            r_op   <= i_cmd.op;
            r_lane <= i_cmd.lane;
            r_ph   <= 2'd0;
            r_wait <= 1'b1;
            if (i_cmd.op == OP_LOAD) begin
                for (int i = 0; i < 3; i++) begin
                    r_p[i] <= {{32{i_in[i][31]}}, i_in[i]};
                    r_d[i] <= {{32{i_in[i+3][31]}}, i_in[i+3]};
                end
                r_wait <= 1'b0;
            end else if (i_cmd.op == OP_DADD) begin
                r_d[i_cmd.lane] <= sadd(r_d[i_cmd.lane], r_u);
                r_wait <= 1'b0;
            end
            if (i_cmd.op == OP_L2 && i_cmd.lane == 2'd0) r_t <= '0;
            if (i_cmd.op == OP_R2 && i_cmd.lane == 2'd0) r_u <= '0;
            if (i_cmd.op == OP_NRM2 && i_cmd.lane == 2'd0) r_t <= '0;
        end else if (r_wait) begin
            if (r_ph == 2'd0 || r_ph == 2'd1) r_ph <= 2'd3;
            if (w_mdone) begin
                case (r_op)
                    OP_CROSS: if (r_ph == 2'd3 && !r_esc) begin
                            r_t <= w_mp; r_ph <= 2'd2; r_esc <= 1'b1;
                        end else begin
                            r_c[r_lane] <= sadd(r_t, 64'd0 - w_mp);
                            r_wait <= 1'b0; r_esc <= 1'b0;
                        end
                    OP_L2:   begin r_t <= sadd(r_t, w_mp); r_wait <= 1'b0; end
                    OP_K1:   begin r_t <= w_mp; r_wait <= 1'b0; end
                    OP_K2:   begin r_k <= w_mp; r_wait <= 1'b0; end
                    OP_R2:   begin r_u <= sadd(r_u, w_mp); r_wait <= 1'b0;
                                   if (r_lane == 2'd2) r_r2 <= sadd(r_u, w_mp); end
                    OP_R4:   begin r_t <= w_mp; r_wait <= 1'b0; end
                    OP_R6:   begin r_r6 <= w_mp; r_wait <= 1'b0; end
                    OP_MOVE: begin r_p[r_lane] <= sadd(r_p[r_lane], w_mp);
                                   r_wait <= 1'b0; end
                    OP_KP:   begin r_u <= w_mp; r_wait <= 1'b0; end
                    OP_NRM2: begin r_t <= sadd(r_t, w_mp); r_wait <= 1'b0; end
                    default: r_wait <= 1'b0;
                endcase
            end
            if (w_ddone) begin
                case (r_op)
                    OP_DIV:  r_u <= w_dq;
                    OP_SQRT: r_nrm <= w_dq;
                    default: r_d[r_lane] <= w_dq;
                endcase
                r_wait <= 1'b0;
            end
            if (r_ph == 2'd2) r_ph <= 2'd1;
        end
    end

    // escape band test on the most recent r squared
    assign o_sts.busy    = r_wait || i_cmd.start;
    assign o_sts.in_band = r_r2 > 64'(i_cap) && r_r2 < 64'(i_esc);
    assign o_sts.escaped = r_r2 > 64'(i_cap);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!r_d[i][63] && r_d[i][62:31] != 32'd0)     o_dir[i] = 32'h7FFF_FFFF;
            else if (r_d[i][63] && r_d[i][62:31] != '1)     o_dir[i] = 32'h8000_0000;
            else                                          o_dir[i] = r_d[i][31:0];
        end
    end

    // r2 register takes the full sum on the last lane; checks: one unit launched at a time, no done while idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mstart |-> !w_dstart) else $error("both units launched");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ddone |-> r_wait) else $error("divider done while idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdone |-> r_wait) else $error("multiplier done while idle");
endmodule
`default_nettype wire

>>> hdl/pgi_ctrl.sv
// controller: sequences setup, the step loop and normalisation
`default_nettype none
module pgi_ctrl
    import pgi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output logic      o_escaped,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_SETUP = 6'b000010, S_TEST = 6'b000100,
        S_STEP = 6'b001000, S_NORM  = 6'b010000, S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    logic [4:0] r_pc;
    logic [STEP_W-1:0] r_n;
    logic r_issued;
    t_op  w_op;
    logic [1:0] w_lane;
    logic [4:0] w_last;

    // micro-program: op and lane per program counter
    always_comb begin
        w_op = OP_NONE; w_lane = 2'd0; w_last = 5'd0;
        case (r_state)
            S_SETUP: begin
                w_last = 5'd11;
                case (r_pc)
                    5'd0: w_op = OP_LOAD;
                    5'd1, 5'd2, 5'd3: begin w_op = OP_CROSS; w_lane = 2'(r_pc - 5'd1); end
                    5'd4, 5'd5, 5'd6: begin w_op = OP_L2; w_lane = 2'(r_pc - 5'd4); end
                    5'd7: w_op = OP_K1;
                    5'd8: w_op = OP_K2;
                    default: begin w_op = OP_R2; w_lane = 2'(r_pc - 5'd9); end
                endcase
            end
            S_STEP: begin
                w_last = 5'd19;
                case (r_pc)
                    5'd0, 5'd1, 5'd2: begin w_op = OP_R2; w_lane = r_pc[1:0]; end
                    5'd3: w_op = OP_R4;
                    5'd4: w_op = OP_R6;
                    5'd5, 5'd6, 5'd7: begin w_op = OP_MOVE; w_lane = 2'(r_pc - 5'd5); end
                    5'd8:  begin w_op = OP_KP;   w_lane = 2'd0; end
                    5'd9:  begin w_op = OP_DIV;  w_lane = 2'd0; end
                    5'd10: begin w_op = OP_DADD; w_lane = 2'd0; end
                    5'd11: begin w_op = OP_KP;   w_lane = 2'd1; end
                    5'd12: begin w_op = OP_DIV;  w_lane = 2'd1; end
                    5'd13: begin w_op = OP_DADD; w_lane = 2'd1; end
                    5'd14: begin w_op = OP_KP;   w_lane = 2'd2; end
                    5'd15: begin w_op = OP_DIV;  w_lane = 2'd2; end
                    5'd16: begin w_op = OP_DADD; w_lane = 2'd2; end
                    default: w_op = OP_NONE;
                endcase
            end
            S_NORM: begin
                w_last = 5'd6;
                case (r_pc)
                    5'd0, 5'd1, 5'd2: begin w_op = OP_NRM2; w_lane = r_pc[1:0]; end
                    5'd3: w_op = OP_SQRT;
                    default: begin w_op = OP_NORM; w_lane = 2'(r_pc - 5'd4); end
                endcase
            end
            default: ;
        endcase
    end

    assign o_cmd.start = !r_issued && (r_state == S_SETUP || r_state == S_STEP
                         || r_state == S_NORM) && w_op != OP_NONE;
    assign o_cmd.op    = w_op;
    assign o_cmd.lane  = w_lane;
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_DONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_n      <= '0;
            r_issued <= 1'b0;
            o_escaped <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_state <= S_SETUP; r_pc <= '0; r_issued <= 1'b0; r_n <= '0;
                end
                S_SETUP, S_STEP, S_NORM: begin
                    if (o_cmd.start) r_issued <= 1'b1;
                    else if (w_op == OP_NONE || (r_issued && !i_sts.busy)) begin
                        r_issued <= 1'b0;
                        if (r_pc == w_last) begin
                            r_pc <= '0;
                            if (r_state == S_NORM) r_state <= S_DONE;
                            else begin
                                r_state <= S_TEST;
                                if (r_state == S_STEP) r_n <= r_n + 1'b1;
                            end
                        end else r_pc <= r_pc + 5'd1;
                    end
                end
                S_TEST: begin
                    if (r_n != STEP_W'(MAX_STEPS) && i_sts.in_band) r_state <= S_STEP;
                    else begin
                        o_escaped <= i_sts.escaped;
                        r_state   <= i_sts.escaped ? S_NORM : S_DONE;
                    end
                end
                S_DONE: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= STEP_W'(MAX_STEPS)) else $error("step count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
endmodule
`default_nettype wire

>>> hdl/photon_geodesic_integrator.sv
// top level: photon geodesic integrator with configuration registers
// run: setup, then up to 6000 steps while the ray stays in the band, then normalising for
//   escaped rays; the bit-serial divides dominate the per-step cost over the multiplies
// throughput: one ray at a time; next request accepted after the result is taken
// the single shared divider sets the per-step cost
// reset: synchronous active low, registers return to step 0.05, capture 1.0, escape 225.0
`default_nettype none
module photon_geodesic_integrator
    import pgi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pgi_ray_if.sink   ray,
    pgi_res_if.source res,
    pgi_cfg_if.sink   cfg
);
    logic [24:0] r_step;
    logic [31:0] r_cap, r_esc;
    logic [31:0] r_in [6];
    logic [31:0] w_dir [3];
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_escaped;

    // configuration writes always accepted
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 25'd838861;
            r_cap  <= 32'd16777216;
            r_esc  <= 32'd3774873600;
        end else if (cfg.valid) begin
            case (cfg.index)
                REG_STEP_SIZE: r_step <= cfg.data[24:0];
                REG_CAPTURE:   r_cap  <= cfg.data;
                REG_ESCAPE:    r_esc  <= cfg.data;
                default: ;
            endcase
        end
    end

    // request payload captured at acceptance, held for the load in the following cycle
    always_ff @(posedge i_clk) begin
        if (ray.valid && ray.ready) begin
            r_in[0] <= ray.pos_x;
            r_in[1] <= ray.pos_y;
            r_in[2] <= ray.pos_z;
            r_in[3] <= ray.dir_x;
            r_in[4] <= ray.dir_y;
            r_in[5] <= ray.dir_z;
        end
    end

    pgi_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(ray.valid), .o_in_ready(ray.ready),
        .o_out_valid(res.valid), .i_out_ready(res.ready),
        .o_escaped(w_escaped), .o_cmd(w_cmd), .i_sts(w_sts)
    );

    pgi_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts), .i_in(r_in),
        .i_step(r_step), .i_cap(r_cap), .i_esc(r_esc), .o_dir(w_dir)
    );

    assign res.escaped   = w_escaped;
    assign res.out_dir_x = w_dir[0];
    assign res.out_dir_y = w_dir[1];
    assign res.out_dir_z = w_dir[2];
endmodule
`default_nettype wire

>>> bench/tb_photon_geodesic_integrator.sv
// testbench: ray requests against a bit-exact geodesic predictor, config sweeps and backpressure
`default_nettype none
module tb_photon_geodesic_integrator;
    import pgi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [63:0] t_fx;

    typedef struct {
        logic               esc;
        logic signed [31:0] dx, dy, dz;
    } t_ray_res;

    localparam t_fx SAT_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_fx SAT_NEG = -64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int  ONE     = 1 << FRAC_BITS;
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = 2'd3;

    logic i_clk;
    logic i_rst_n;

    pgi_ray_if ray_ch ();
    pgi_res_if res_ch ();
    pgi_cfg_if cfg_ch ();

    photon_geodesic_integrator u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .ray    (ray_ch),
        .res    (res_ch),
        .cfg    (cfg_ch)
    );

    // mirror of the block's registers, used by the predictor
    logic [24:0] step_q;
    logic [31:0] capture_q;
    logic [31:0] escape_q;

    t_ray_res expected_dirs[$];
    int       fail_cnt;
    int       hold_left;     // long receiver hold-off, counted down by the receiver
    bit       no_idle;       // stretches with no idling on either side

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // fixed point arithmetic, saturating to +-(2^63-1)
    // ---------------------------------------------------------------
    function automatic logic [63:0] fx_mag(input t_fx a);
        return a < 0 ? 64'd0 - a : a;
    endfunction

    function automatic t_fx fx_signed(input logic [63:0] m, input logic neg);
        t_fx v;
        v = m[63] ? SAT_POS : t_fx'(m);
        return neg ? -v : v;
    endfunction

    function automatic t_fx fx_add(input t_fx a, input t_fx b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return SAT_POS;
        if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) return SAT_NEG;
        return s[63:0];
    endfunction

    // product rounded toward zero
    function automatic t_fx fx_mul(input t_fx a, input t_fx b);
        logic [127:0] pr;
        logic [63:0]  m;
        pr = {64'd0, fx_mag(a)} * {64'd0, fx_mag(b)};
        pr = pr >> FRAC_BITS;
        m  = (pr[127:63] != 0) ? SAT_POS : pr[63:0];
        return fx_signed(m, (a < 0) != (b < 0));
    endfunction

    // quotient rounded toward zero, divide by zero saturates with the sign, zero by zero gives zero
    function automatic t_fx fx_div(input t_fx a, input t_fx b);
        logic [63:0]  ua, ub, m;
        logic [127:0] q;
        if (b == 0) begin
            if (a == 0) return 0;
            return a < 0 ? SAT_NEG : SAT_POS;
        end
        ua = fx_mag(a);
        ub = fx_mag(b);
        if (ua / ub > (SAT_POS >> FRAC_BITS)) begin
            m = SAT_POS;
        end else begin
            q = ({64'd0, ua} << FRAC_BITS) / {64'd0, ub};
            m = q[63:0];
        end
        return fx_signed(m, (a < 0) != (b < 0));
    endfunction

    function automatic t_fx fx_sqrt(input t_fx v);
        logic [127:0] t, c;
        logic [63:0]  r;
        t = (v < 0) ? 128'd0 : ({64'd0, v} << FRAC_BITS);
        r = 0;
        for (int b = 46; b >= 0; b--) begin
            c = {64'd0, r | (64'd1 << b)};
            if (c * c <= t) r = c[63:0];
        end
        return t_fx'(r);
    endfunction

    function automatic t_fx fx_norm2(input t_fx a, input t_fx b, input t_fx c);
        return fx_add(fx_add(fx_mul(a, a), fx_mul(b, b)), fx_mul(c, c));
    endfunction

    function automatic logic signed [31:0] fx_to32(input t_fx v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // ---------------------------------------------------------------
    // geodesic predictor: euler steps, at most MAX_STEPS, until the ray leaves the band
    // ---------------------------------------------------------------
    function automatic t_ray_res trace_ray(input logic signed [31:0] px, py, pz,
                                           input logic signed [31:0] vx, vy, vz);
        t_fx      p[3], d[3], c[3];
        t_fx      l2, k, r2, r6, st, nrm;
        int       n;
        t_ray_res r;
        p[0] = px; p[1] = py; p[2] = pz;
        d[0] = vx; d[1] = vy; d[2] = vz;
        st = t_fx'({39'd0, step_q});
        // angular momentum from the cross product
        c[0] = fx_add(fx_mul(p[1], d[2]), -fx_mul(d[1], p[2]));
        c[1] = fx_add(fx_mul(d[0], p[2]), -fx_mul(p[0], d[2]));
        c[2] = fx_add(fx_mul(p[0], d[1]), -fx_mul(d[0], p[1]));
        l2 = fx_norm2(c[0], c[1], c[2]);
        k  = fx_mul(-(t_fx'(3) << (FRAC_BITS - 1)), fx_mul(l2, st));
        r2 = fx_norm2(p[0], p[1], p[2]);
        n  = 0;
        while (n < MAX_STEPS && $unsigned(r2) > {32'd0, capture_q}
               && $unsigned(r2) < {32'd0, escape_q}) begin
            n++;
            r2 = fx_norm2(p[0], p[1], p[2]);
            r6 = fx_mul(fx_mul(r2, r2), r2);
            for (int i = 0; i < 3; i++) p[i] = fx_add(p[i], fx_mul(d[i], st));
            for (int i = 0; i < 3; i++) d[i] = fx_add(d[i], fx_div(fx_mul(k, p[i]), r6));
        end
        r.esc = $unsigned(r2) > {32'd0, capture_q};
        if (r.esc) begin
            nrm = fx_sqrt(fx_norm2(d[0], d[1], d[2]));
            for (int i = 0; i < 3; i++) d[i] = fx_div(d[i], nrm);
        end
        r.dx = fx_to32(d[0]);
        r.dy = fx_to32(d[1]);
        r.dz = fx_to32(d[2]);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------
    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic send_ray(input logic signed [31:0] px, py, pz, vx, vy, vz);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            ray_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ray_ch.valid <= 1'b1;
        ray_ch.pos_x <= px;
        ray_ch.pos_y <= py;
        ray_ch.pos_z <= pz;
        ray_ch.dir_x <= vx;
        ray_ch.dir_y <= vy;
        ray_ch.dir_z <= vz;
        @(posedge i_clk);
        while (!ray_ch.ready) @(posedge i_clk);
        // accepted at this edge; registers are stable during the phase
        expected_dirs.push_back(trace_ray(px, py, pz, vx, vy, vz));
    endtask

    // wait until every outstanding result is back, with the request line low
    task automatic drain_results();
        ray_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_dirs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // one write, then the channel idles before the task returns
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_STEP_SIZE: step_q    = data[24:0];
            REG_CAPTURE:   capture_q = data;
            REG_ESCAPE:    escape_q  = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_band(input logic [31:0] st, input logic [31:0] cap,
                            input logic [31:0] esc);
        drain_results();
        write_reg(REG_STEP_SIZE, st);
        write_reg(REG_CAPTURE, cap);
        write_reg(REG_ESCAPE, esc);
    endtask

    // ---------------------------------------------------------------
    // result side: random ready, long hold-off on request, field checks
    // ---------------------------------------------------------------
    initial begin
        int       gap;
        t_ray_res exp_r;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (hold_left > 0 || gap > 0) begin
                res_ch.ready <= 1'b0;
                while (hold_left > 0) begin
                    @(posedge i_clk);
                    hold_left--;
                end
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            if (expected_dirs.size() == 0) begin
                $display("%0t: result with none expected: esc=%0b dir=%0d %0d %0d", $time,
                         res_ch.escaped, res_ch.out_dir_x, res_ch.out_dir_y,
                         res_ch.out_dir_z);
                fail_cnt++;
            end else begin
                exp_r = expected_dirs.pop_front();
                if (res_ch.escaped !== exp_r.esc) begin
                    $display("%0t: escaped expected %0b actual %0b", $time, exp_r.esc,
                             res_ch.escaped);
                    fail_cnt++;
                end
                if (res_ch.out_dir_x !== exp_r.dx) begin
                    $display("%0t: out_dir_x expected %0d actual %0d", $time, exp_r.dx,
                             res_ch.out_dir_x);
                    fail_cnt++;
                end
                if (res_ch.out_dir_y !== exp_r.dy) begin
                    $display("%0t: out_dir_y expected %0d actual %0d", $time, exp_r.dy,
                             res_ch.out_dir_y);
                    fail_cnt++;
                end
                if (res_ch.out_dir_z !== exp_r.dz) begin
                    $display("%0t: out_dir_z expected %0d actual %0d", $time, exp_r.dz,
                             res_ch.out_dir_z);
                    fail_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // rays outside the band at reset settings: no step is taken
    task automatic test_outside_band();
        send_ray(20 * ONE, 0, 0, ONE, 0, 0);                  // beyond escape radius
        send_ray(0, 0, 0, 3 * ONE, -ONE, 7);                  // at origin, captured
        send_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, -1);
        send_ray(16 * ONE, 0, 0, 0, 0, 0);                    // escaped with zero direction
        send_ray(ONE / 4, 0, ONE / 4, 32'sh8000_0000, 5, 32'sh7FFF_FFFF); // captured
    endtask

    // rays that step through the band with a coarse step
    task automatic test_in_band();
        set_band(ONE, ONE, 225 * ONE);
        send_ray(3 * ONE, 0, 0, ONE, ONE / 3, 0);             // bends and escapes
        send_ray(3 * ONE, 0, 0, -ONE, 0, 0);                  // falls in
        send_ray(0, -4 * ONE, ONE, ONE / 2, ONE, -ONE / 4);
        send_ray(2 * ONE, 2 * ONE, 0, -ONE, ONE, 0);          // grazing pass
        set_band(ONE / 2, 0, 64 * ONE);
        send_ray(-5 * ONE, ONE, 2 * ONE, ONE, 0, -ONE);
        // tiny radius with zero capture: r^6 underflows to zero
        send_ray(4096, 0, 0, 0, ONE, 0);
        send_ray(0, 0, 4096, ONE, 0, 0);
        send_ray(0, 0, 0, ONE, 0, 0);                         // r2 of zero is not in band
    endtask

    // extreme register settings
    task automatic test_register_extremes();
        set_band(1, 32'hFFFF_FFFF, 0);                        // empty band
        send_ray(3 * ONE, 0, 0, ONE, 0, 0);
        send_ray(32'sh7FFF_FFFF, 0, 0, 0, 0, 32'sh8000_0000);
        set_band(25'h1FF_FFFF, 0, 32'hFFFF_FFFF);             // largest step and band
        send_ray(ONE, ONE, ONE, 4 * ONE, -3 * ONE, 2 * ONE);
        send_ray(-ONE, 2 * ONE, 0, 0, -8 * ONE, ONE);
        drain_results();
        write_reg(REG_UNKNOWN, 32'hDEAD_BEEF);                // unknown index, ignored
        send_ray(2 * ONE, 0, ONE, ONE, ONE, 0);
    endtask

    // ray that never moves with the smallest step: runs to the step limit
    task automatic test_step_timeout();
        set_band(1, ONE, 225 * ONE);
        send_ray(5 * ONE, 0, 0, 0, 0, 0);
    endtask

    function automatic logic signed [31:0] rand_coord(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // random rays: mostly well formed in-band rays, some raw noise
    task automatic test_random_rays();
        logic signed [31:0] p[3], d[3];
        set_band(ONE, ONE, 100 * ONE);
        for (int n = 0; n < 80; n++) begin
            if (n == 30) set_band(ONE / 2 + $urandom_range(0, ONE / 2), ONE / 2, 144 * ONE);
            if (n == 65) set_band(ONE, 2 * ONE, 64 * ONE);
            no_idle = (n >= 45 && n < 55);
            // long receiver hold-off: the block holds its result and stalls requests
            if (n == 20) hold_left = 3000;
            // pause until every outstanding result is back
            if (n == 72) drain_results();
            if ($urandom_range(0, 3) == 0) begin
                for (int i = 0; i < 3; i++) begin
                    p[i] = $urandom();
                    d[i] = $urandom();
                end
            end else begin
                for (int i = 0; i < 3; i++) begin
                    p[i] = rand_coord(7 * ONE);
                    d[i] = rand_coord(2 * ONE);
                end
                // keep the ray moving so it leaves the band quickly
                d[$urandom_range(0, 2)] = ($urandom_range(0, 1) ? 1 : -1)
                                          * $signed($urandom_range(ONE, 2 * ONE));
            end
            send_ray(p[0], p[1], p[2], d[0], d[1], d[2]);
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        fail_cnt  = 0;
        hold_left = 0;
        no_idle   = 1'b0;
        step_q    = 25'd838861;
        capture_q = 32'd16777216;
        escape_q  = 32'd3774873600;
        i_rst_n      <= 1'b0;
        ray_ch.valid <= 1'b0;
        ray_ch.pos_x <= '0;
        ray_ch.pos_y <= '0;
        ray_ch.pos_z <= '0;
        ray_ch.dir_x <= '0;
        ray_ch.dir_y <= '0;
        ray_ch.dir_z <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_outside_band();
        test_in_band();
        test_register_extremes();
        test_step_timeout();
        test_random_rays();

        // let the last ray finish, then allow a normalising pass of slack
        drain_results();
        repeat (1000) @(posedge i_clk);
        if (fail_cnt == 0 && expected_dirs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog: several times the run with every ray at the step limit
    initial begin
        #6s;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
